>>> design/cbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cbc_pkg;
  localparam logic [63:0] CHAIN_IV = 64'h11096919991927FE;
  localparam logic [63:0] BIV_ONE  = 64'hD34C027BE8579632;
  localparam logic [63:0] BIV_TWO  = 64'hFBE852461ACD3970;
  localparam logic [31:0] SCHED_IV_ONE = 32'h6f2ba36a;
  localparam logic [31:0] SCHED_IV_TWO = 32'he7c4e584;
  localparam logic [1:0] REG_KEY  = 2'd0;
  localparam logic [1:0] REG_MODE = 2'd1;
  localparam logic [1:0] REG_DEC  = 2'd2;

  typedef struct packed {
    logic       variant_b;
    logic       second_iv;
    logic       dec;
  } core_ctl_t;

  function automatic logic [31:0] bswap(input logic [31:0] v);
    bswap = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [31:0] brot(input logic [31:0] v);
    logic [31:0] s;
    s = bswap(v);
    brot = bswap({s[30:0], s[31]});
  endfunction

  function automatic logic [7:0] rol8(input logic [7:0] v);
    rol8 = {v[6:0], v[7]};
  endfunction

  function automatic logic [7:0] box_of(input logic [3:0] r);
    logic [7:0] b;
    logic [1:0] nr;
    unique case (r[3:2])
      2'd0: b = 8'h46;
      2'd1: b = 8'hA2;
      2'd2: b = 8'h72;
      default: b = 8'h41;
    endcase
    nr = ~r[1:0];
    box_of = b >> {nr, 1'b0};
  endfunction

  function automatic logic [31:0] round_fn(input logic [31:0] ci, input logic [31:0] p,
                                           input logic [1:0] box);
    logic [15:0] cc, l0, l1, p0, p1;
    logic [31:0] c, rot, m, t;
    logic        par;
    cc = box[1] ? 16'h5353 : 16'h0000;
    l0 = {ci[7:0], ci[15:8]};
    l1 = {ci[23:16], ci[31:24]};
    p0 = {p[7:0], p[15:8]};
    p1 = {p[23:16], p[31:24]};
    l0 = l0 + p0 + cc;
    l1 = l1 + p1 + cc;
    c = {l1[7:0], l1[15:8], l0[7:0], l0[15:8]};
    c = ((c & 32'hf0f0f0f0) >> 4) | ((c & 32'h0f0f0f0f) << 4);
    rot = brot(p);
    m = c & rot;
    par = ^m;
    if (par) c = c ^ (32'hffffffff ^ rot);
    t = bswap(c);
    if (!box[0])
      t = ((t & 32'h00000055) << 1) | ((t & 32'h0000aa00) << 7) |
          ((t & 32'h00550000) << 9) | ((t & 32'h000000aa) << 16) |
          (t & 32'h55000000) | ((t & 32'h00aa5500) >> 8) | ((t & 32'haa000000) >> 17);
    else
      t = ((t & 32'h00aa0000) << 7) | ((t & 32'h00005500) << 9) |
          ((t & 32'h00000055) << 16) | (t & 32'haa000000) |
          ((t & 32'h000000aa) >> 1) | ((t & 32'h0055aa00) >> 8) | ((t & 32'h55000000) >> 15);
    c = bswap(t);
    round_fn = c ^ bswap({t[23:0], t[31:24]}) ^ brot(c);
  endfunction

  function automatic logic [7:0] sub_tab(input logic [7:0] i);
    logic [7:0] tb [256];
    tb = '{
      8'hAA,8'hA2,8'h10,8'hFA,8'hA9,8'hF0,8'h40,8'h2F,8'hB1,8'h1C,8'h1A,8'h6F,8'h43,8'hB4,8'h73,8'hBC,
      8'h69,8'h77,8'hC5,8'h00,8'hF3,8'hD4,8'h09,8'h7E,8'h58,8'h8D,8'h44,8'hC3,8'hF5,8'h54,8'h0C,8'hDD,
      8'h3F,8'hB7,8'hD1,8'hD6,8'h9A,8'hD3,8'h39,8'h82,8'h01,8'h5E,8'h03,8'hED,8'h78,8'h63,8'h90,8'h49,
      8'h9B,8'h15,8'hA8,8'h4F,8'h67,8'h52,8'hAC,8'hE4,8'h37,8'hEA,8'hF7,8'h23,8'h55,8'h0F,8'h42,8'h12,
      8'hE3,8'h05,8'h5F,8'h2D,8'h2E,8'h7F,8'h11,8'h38,8'h07,8'hF4,8'h3C,8'hE2,8'hD5,8'h9F,8'hDF,8'hCF,
      8'h30,8'h0B,8'hAD,8'h66,8'h22,8'h70,8'hEF,8'h7B,8'hA6,8'h24,8'h65,8'h0D,8'h5D,8'h79,8'h02,8'h4D,
      8'h0E,8'h32,8'h84,8'h97,8'hB8,8'h57,8'h34,8'hE8,8'h41,8'h87,8'hC1,8'hF9,8'h9C,8'h56,8'hAE,8'h71,
      8'hAB,8'hBF,8'hD0,8'h88,8'h25,8'hC8,8'h1F,8'hD7,8'hFE,8'h04,8'h4E,8'hCE,8'h51,8'h81,8'hBB,8'hCD,
      8'h91,8'hA5,8'h14,8'h75,8'hA4,8'h60,8'h61,8'h6E,8'h7A,8'hE6,8'h99,8'hD8,8'hA0,8'h4C,8'hDC,8'h1B,
      8'h06,8'h6C,8'h3E,8'h9E,8'hF8,8'hCB,8'h98,8'h92,8'h0A,8'hFB,8'h2A,8'hCA,8'h50,8'h7C,8'hC0,8'h83,
      8'h94,8'hB5,8'h6A,8'h21,8'h95,8'hB3,8'h48,8'hD9,8'h16,8'hA7,8'hEE,8'h4B,8'hFD,8'h9D,8'hBD,8'h6B,
      8'hC6,8'h80,8'h20,8'h3A,8'h53,8'h1E,8'h5C,8'hC7,8'hB6,8'h08,8'hAF,8'hA1,8'h2B,8'h19,8'h26,8'h8A,
      8'h47,8'hE1,8'h86,8'h74,8'hE9,8'h59,8'h62,8'h8B,8'h28,8'h6D,8'hEC,8'h76,8'hB0,8'h45,8'hC2,8'h46,
      8'h4A,8'hE0,8'hF2,8'h8C,8'hBE,8'h3B,8'h5B,8'hBA,8'h31,8'h96,8'hE5,8'h36,8'h8E,8'hEB,8'hE7,8'hB9,
      8'hA3,8'h35,8'h17,8'h68,8'h27,8'h8F,8'h85,8'h89,8'h29,8'h93,8'hFF,8'hFC,8'hDE,8'h7D,8'h18,8'hDB,
      8'h64,8'hF6,8'h1D,8'hB2,8'h3D,8'hF1,8'hC9,8'h13,8'hDA,8'hCC,8'hC4,8'h72,8'h33,8'h5A,8'hD2,8'h2C};
    sub_tab = tb[i];
  endfunction

  function automatic logic [31:0] scramble(input logic [31:0] a, input logic [31:0] k);
    logic [31:0] w;
    logic [7:0] b0, b1, b2, b3;
    w = a ^ k;
    b0 = sub_tab(w[7:0]);
    b1 = sub_tab(w[15:8]);
    b2 = sub_tab(w[23:16]);
    b3 = sub_tab(w[31:24]);
    b1 = b1 ^ rol8(b0);
    b0 = b0 ^ rol8(b1);
    b3 = b3 ^ rol8(b2);
    b2 = b2 ^ rol8(b3);
    b1 = b1 ^ rol8(rol8(b2));
    b2 = b2 ^ rol8(rol8(b1));
    b3 = b3 ^ rol8(rol8(b0));
    b0 = b0 ^ rol8(rol8(b3));
    scramble = {b3, b2, b1, b0};
  endfunction
endpackage
`default_nettype wire

>>> design/cbc_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cbc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_data;
  logic [3:0]  byte_count;
  logic        first_block;
  modport source (output valid, block_data, byte_count, first_block, input ready);
  modport sink (input valid, block_data, byte_count, first_block, output ready);
endinterface

interface cbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_data;
  logic [3:0]  out_byte_count;
  modport source (output valid, out_data, out_byte_count, input ready);
  modport sink (input valid, out_data, out_byte_count, output ready);
endinterface
`default_nettype wire

>>> design/cbc_sched_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module cbc_sched_mem (
  input  wire logic        clk,
  input  wire logic        we,
  input  wire logic [3:0]  waddr,
  input  wire logic [31:0] wdata,
  input  wire logic [3:0]  raddr,
  output logic [31:0]      rdata
);
  logic [31:0] mem [16];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/cbc_block_cipher_two_variant.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Fields
// in      | in  | block_data[63:0], byte_count[3:0], first_block
// out     | out | out_data[63:0], out_byte_count[3:0]
// cfg     | in  | APB, paddr[4:0]: key @0x0, protocol_mode @0x8, decrypt_mode @0x10
// An item passes through setup, 16 rounds with the schedule memory read one round
// ahead, and finish after its accepting edge; the Feistel loop over the single-port
// read sets this. The result must leave before the next item is taken, so a new
// item is not accepted until the result of the last one has left.
// A first_block item adds the schedule build: variant A runs 8 rounds plus 12
// zeroing writes, variant B writes all 16 schedule words.
// Reset clears control, state and the result valid, and loads the chaining value
// with CHAIN_IV; the schedule memory is undefined until the first first_block item. A held result stalls new items.
module cbc_block_cipher_two_variant (
  input  wire logic        clk,
  input  wire logic        rst_n,
  cbc_in_if.sink           in_ch,
  cbc_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);
  import cbc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCHA  = 3'd1;
  localparam logic [2:0] ST_SCHB  = 3'd2;
  localparam logic [2:0] ST_PRE   = 3'd3;
  localparam logic [2:0] ST_ROUND = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [63:0] key_r;
  logic [7:0]  mode_r;
  logic        dec_r;
  logic [2:0]  state_r;
  logic [4:0]  cnt_r;
  logic [63:0] chain_r, data_r, work_r;
  logic [3:0]  n_r;
  logic        dec_op_r, full_r;
  logic [31:0] pa_r;          // variant A schedule chain value
  logic [31:0] w0_r, w1_r, w2_r, w3_r;
  logic [63:0] kb_r;          // variant B key bytes
  logic [31:0] a_r, b_r;
  logic        ov_r;
  logic [63:0] od_r;
  logic [3:0]  on_r;
  core_ctl_t   ctl;

  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata;

  cbc_sched_mem u_mem (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  assign ctl = '{variant_b: mode_r[6], second_iv: |mode_r[3:2], dec: dec_op_r};
  assign cfg_pready = 1'b1;
  always_comb begin
    unique case (cfg_paddr[4:3])
      REG_KEY:  cfg_prdata = key_r;
      REG_MODE: cfg_prdata = {56'd0, mode_r};
      REG_DEC:  cfg_prdata = {63'd0, dec_r};
      default:  cfg_prdata = 64'd0;
    endcase
  end

  wire accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.out_data = od_r;
  assign out_ch.out_byte_count = on_r;

  // Round index of the round being computed now; schedule word read for next.
  wire [3:0] ri = cnt_r[3:0];
  wire [3:0] nxt_i = ri + 4'd1;
  wire [3:0] ph_next = ctl.dec ? ~nxt_i : nxt_i;
  wire [3:0] rr = ctl.dec ? ~ri : ri;
  wire [3:0] rd_idx = ctl.variant_b ? ph_next : {2'b00, ph_next[1:0]};
  wire [63:0] ivb = ctl.second_iv ? BIV_TWO : BIV_ONE;
  wire [63:0] core_in = (full_r && !dec_op_r) ? (data_r ^ chain_r) :
                        (full_r ? data_r : chain_r);

  // Variant A schedule round source word
  logic [31:0] sa_src;
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0: sa_src = w0_r;
      2'd1: sa_src = w1_r;
      2'd2: sa_src = w2_r;
      default: sa_src = w3_r;
    endcase
  end
  wire [31:0] sa_out = round_fn(sa_src, pa_r, 2'b00);

  // Variant B schedule step
  logic [7:0] s0, s1, s2, s3;
  always_comb begin
    s0 = kb_r[7:0] + sub_tab(kb_r[15:8]);
    s1 = kb_r[23:16] ^ sub_tab(kb_r[31:24]);
    s2 = kb_r[39:32] ^ sub_tab(kb_r[47:40]);
    s3 = kb_r[55:48] + sub_tab(kb_r[63:56]);
  end

  wire [7:0]  rbox = box_of(rr);
  wire [31:0] fa = a_r ^ round_fn(b_r, rdata, rbox[1:0]);
  wire [31:0] fb = a_r ^ scramble(b_r, rdata);
  wire [63:0] mask = (cnt_r == 5'd0) ? 64'd0 : 64'd0;

  always_comb begin
    we = 1'b0; waddr = cnt_r[3:0]; wdata = 32'd0;
    raddr = rd_idx;
    if (state_r == ST_SCHA) begin
      we = 1'b1;
      if (cnt_r < 5'd8) begin
        waddr = {2'b00, cnt_r[1:0]}; wdata = sa_out;
      end else begin
        waddr = cnt_r[3:0] - 4'd4; wdata = 32'd0;
      end
    end else if (state_r == ST_SCHB) begin
      we = 1'b1; wdata = {s3, s2, s1, s0};
    end
    if (state_r == ST_PRE) raddr = ctl.variant_b ? (ctl.dec ? 4'd15 : 4'd0)
                                                 : (ctl.dec ? 4'd3 : 4'd0);
  end

  logic [63:0] res;
  logic [63:0] wb;
  always_comb begin
    if (ctl.variant_b) wb = {b_r, a_r} - ivb;
    else wb = {a_r, b_r};
    if (full_r) res = dec_op_r ? (wb ^ chain_r) : wb;
    else res = (wb ^ data_r) & ((64'd1 << {n_r[2:0], 3'b000}) - 64'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0; mode_r <= '0; dec_r <= 1'b0;
      state_r <= ST_IDLE; cnt_r <= '0; chain_r <= CHAIN_IV; work_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        unique case (cfg_paddr[4:3])
          REG_KEY:  key_r <= cfg_pwdata;
          REG_MODE: mode_r <= cfg_pwdata[7:0];
          REG_DEC:  dec_r <= cfg_pwdata[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (accept) begin
          data_r <= in_ch.block_data;
          n_r <= (in_ch.byte_count > 4'd8) ? 4'd8 : in_ch.byte_count;
          full_r <= in_ch.byte_count >= 4'd8;
          dec_op_r <= dec_r && (in_ch.byte_count >= 4'd8);
          cnt_r <= '0;
          w0_r <= key_r[31:0]; w1_r <= key_r[63:32];
          w2_r <= 32'h0b0a0908; w3_r <= 32'h0f0e0d0c;
          pa_r <= (|mode_r[3:2]) ? SCHED_IV_TWO : SCHED_IV_ONE;
          kb_r <= key_r;
          if (in_ch.first_block) begin
            chain_r <= CHAIN_IV;
            state_r <= mode_r[6] ? ST_SCHB : ST_SCHA;
          end else if (in_ch.byte_count == 4'd0) state_r <= ST_IDLE;
          else state_r <= ST_PRE;
        end
        ST_SCHA: begin
          if (cnt_r < 5'd8) begin
            pa_r <= sa_out;
            unique case (cnt_r[1:0])
              2'd0: w0_r <= sa_out;
              2'd1: w1_r <= sa_out;
              2'd2: w2_r <= sa_out;
              default: w3_r <= sa_out;
            endcase
          end
          if (cnt_r == 5'd19) begin
            cnt_r <= '0; state_r <= (n_r == 4'd0) ? ST_IDLE : ST_PRE;
          end else cnt_r <= cnt_r + 5'd1;
        end
        ST_SCHB: begin
          kb_r <= {s0, kb_r[63:56], s3, kb_r[47:40], s2, kb_r[31:24], s1, kb_r[15:8]};
          if (cnt_r == 5'd15) begin
            cnt_r <= '0; state_r <= (n_r == 4'd0) ? ST_IDLE : ST_PRE;
          end else cnt_r <= cnt_r + 5'd1;
        end
        ST_PRE: begin
          if (ctl.variant_b) begin
            {b_r, a_r} <= core_in + ivb;
          end else begin
            {b_r, a_r} <= core_in;
          end
          cnt_r <= '0; state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          if (ctl.variant_b) begin
            if (cnt_r[3:0] == 4'd15) a_r <= fb;
            else begin a_r <= b_r; b_r <= fb; end
          end else begin
            a_r <= b_r; b_r <= fa;
          end
          if (cnt_r == 5'd15) state_r <= ST_FIN;
          cnt_r <= cnt_r + 5'd1;
        end
        ST_FIN: begin
          work_r <= wb ^ mask;
          od_r <= res; on_r <= n_r; ov_r <= 1'b1;
          if (full_r) chain_r <= dec_op_r ? data_r : res;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> ov_r) else $error("result not raised");
  a_round_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (cnt_r < 5'd16)) else $error("round count");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> (ov_r && $stable(od_r))) else $error("result lost");
`endif
endmodule
`default_nettype wire
